FILE: rtl/gcd_pkg.sv
`timescale 1ns / 1ps
// gcd_pkg: constants shared by the great-circle distance pipeline
// no dependencies; used by the interfaces, gcd_sine, gcd_asin and the top level

package gcd_pkg;

    // default parameter values for the top level
    localparam int ANGLE_WIDTH_DEF    = 32;
    localparam int DIST_FRAC_BITS_DEF = 16;

    // fixed widths
    localparam int Q_W      = 34;   // q30 magnitude of an angle or difference
    localparam int DIST_W   = 34;   // distance field
    localparam int RADIUS_W = 16;   // sphere radius register
    localparam int QF       = 30;   // fraction bits of internal unsigned values

    // q30 constants
    localparam logic [30:0] ONE_Q     = 31'h4000_0000;
    localparam logic [30:0] HALF_ONE  = 31'h2000_0000;
    localparam logic [31:0] PI_Q      = 32'd3373259426;
    localparam logic [30:0] HALF_PI_Q = 31'd1686629713;

    // whole multiples of pi for range reduction
    localparam logic [35:0] PI_MULT [7] = '{
        36'd0, 36'd3373259426, 36'd6746518852, 36'd10119778278,
        36'd13493037704, 36'd16866297130, 36'd20239556556
    };

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd6371;

    // sine unit: one stage for x squared, three per series term, one for the product
    localparam int SINE_STEPS = 8;
    localparam int SINE_LAT   = 3 * SINE_STEPS + 2;

    // arcsine search: one sine evaluation plus a decision stage per result bit
    localparam int ASIN_BITS = 31;
    localparam int ASIN_LAT  = ASIN_BITS * (SINE_LAT + 1);

    // square root: one result bit per stage
    localparam int ISQ_BITS = 30;

endpackage

FILE: rtl/gcd_in_if.sv
`timescale 1ns / 1ps
// gcd_in_if: input channel carrying one pair of points per item
// depends on gcd_pkg for the default angle width

interface gcd_in_if import gcd_pkg::*; #(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [ANGLE_WIDTH-1:0] lat_a;
    logic signed [ANGLE_WIDTH-1:0] lon_a;
    logic signed [ANGLE_WIDTH-1:0] lat_b;
    logic signed [ANGLE_WIDTH-1:0] lon_b;

    modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
    modport sink   (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

FILE: rtl/gcd_out_if.sv
`timescale 1ns / 1ps
// gcd_out_if: output channel carrying one distance per item
// depends on gcd_pkg for the distance width

interface gcd_out_if import gcd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;

    modport source (output valid, distance, input ready);
    modport sink   (input valid, distance, output ready);
endinterface

FILE: rtl/gcd_sine.sv
`timescale 1ns / 1ps
// gcd_sine: pipelined fixed-point sine series on [0, pi/2], q30 in and out
// depends on gcd_pkg; advances when i_en is high

module gcd_sine import gcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_x,
    output logic [30:0] o_s
);

    logic [30:0] w_x  [SINE_STEPS+1];
    logic [31:0] w_x2 [SINE_STEPS+1];
    logic [30:0] w_t  [SINE_STEPS+1];

    logic [30:0] r_x0;
    logic [31:0] r_x20;
    logic [61:0] w_sq;
    logic [61:0] w_pf;

    // square of the argument
    assign w_sq = 62'(i_x) * 62'(i_x);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x0  <= i_x;
            r_x20 <= w_sq[61:30];
        end
    end

    assign w_x[0]  = r_x0;
    assign w_x2[0] = r_x20;
    assign w_t[0]  = ONE_Q;

    // one series term per step, highest order first
    for (genvar j = 0; j < SINE_STEPS; j++) begin : g_step
        localparam longint unsigned K   = longint'(SINE_STEPS - j);
        localparam longint unsigned DEN = (2 * K) * (2 * K + 1);
        localparam longint unsigned RCP = (64'd1 << 32) / DEN;

        logic [62:0] w_pa;
        logic [61:0] w_pb;
        logic [33:0] w_rem;
        logic [30:0] w_q;
        logic [31:0] r_ya, r_yb, r_x2a, r_x2b, r_x2c;
        logic [30:0] r_xa, r_xb, r_xc, r_t;
        logic [29:0] r_q0;

        // x2 * t
        assign w_pa = 63'(w_x2[j]) * 63'(w_t[j]);
        // quotient estimate by reciprocal
        assign w_pb = 62'(r_ya) * 62'(RCP);
        // one correction step, then the new term
        assign w_rem = 34'(r_yb) - 34'(r_q0) * 34'(DEN);
        assign w_q   = 31'(r_q0) + ((w_rem >= 34'(DEN)) ? 31'd1 : 31'd0);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ya  <= w_pa[61:30];
                r_xa  <= w_x[j];
                r_x2a <= w_x2[j];
                r_q0  <= w_pb[61:32];
                r_yb  <= r_ya;
                r_xb  <= r_xa;
                r_x2b <= r_x2a;
                r_t   <= ONE_Q - w_q;
                r_xc  <= r_xb;
                r_x2c <= r_x2b;
            end
        end

        assign w_x[j+1]  = r_xc;
        assign w_x2[j+1] = r_x2c;
        assign w_t[j+1]  = r_t;
    end

    // final product x * t
    assign w_pf = 62'(w_x[SINE_STEPS]) * 62'(w_t[SINE_STEPS]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_s <= w_pf[60:30];
        end
    end

endmodule

FILE: rtl/gcd_asin.sv
`timescale 1ns / 1ps
// gcd_asin: arcsine by bitwise search, one sine unit per result bit
// depends on gcd_pkg and gcd_sine

module gcd_asin import gcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [29:0] i_r,
    output logic [30:0] o_th
);

    logic [30:0] w_th [ASIN_BITS+1];
    logic [29:0] w_r  [ASIN_BITS+1];

    assign w_th[0] = '0;
    assign w_r[0]  = i_r;

    for (genvar j = 0; j < ASIN_BITS; j++) begin : g_bit
        localparam int B = ASIN_BITS - 1 - j;

        logic [30:0] w_c;
        logic        w_ok;
        logic [30:0] w_s;
        logic [30:0] r_thd [SINE_LAT];
        logic [30:0] r_cd  [SINE_LAT];
        logic [29:0] r_rd  [SINE_LAT];
        logic        r_okd [SINE_LAT];
        logic [30:0] r_tho;
        logic [29:0] r_ro;

        // candidate with this bit set
        assign w_c  = w_th[j] | (31'd1 << B);
        assign w_ok = (w_c <= HALF_PI_Q);

        gcd_sine u_sine (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x   (w_c),
            .o_s   (w_s)
        );

        // carry the search state alongside the sine unit
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_thd[0] <= w_th[j];
                r_cd[0]  <= w_c;
                r_rd[0]  <= w_r[j];
                r_okd[0] <= w_ok;
                for (int i = 1; i < SINE_LAT; i++) begin
                    r_thd[i] <= r_thd[i-1];
                    r_cd[i]  <= r_cd[i-1];
                    r_rd[i]  <= r_rd[i-1];
                    r_okd[i] <= r_okd[i-1];
                end
            end
        end

        // keep the bit when the candidate stays in range and its sine does not exceed the target
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tho <= (r_okd[SINE_LAT-1] && (w_s <= 31'(r_rd[SINE_LAT-1])))
                         ? r_cd[SINE_LAT-1] : r_thd[SINE_LAT-1];
                r_ro  <= r_rd[SINE_LAT-1];
            end
        end

        assign w_th[j+1] = r_tho;
        assign w_r[j+1]  = r_ro;
    end

    assign o_th = w_th[ASIN_BITS];

endmodule

FILE: rtl/great_circle_distance.sv
`timescale 1ns / 1ps
// great_circle_distance: haversine distance pipeline, one pair of points per item
// depends on gcd_pkg, gcd_in_if, gcd_out_if, gcd_sine and gcd_asin
//
//  channel    dir  handshake            payload
//  i_pt       in   valid / ready        lat_a, lon_a, lat_b, lon_b (signed q2.29)
//  o_dist     out  valid / ready        distance (km, DIST_FRAC_BITS fraction bits)
//  i_cfg_*    in   write enable only    sphere radius in km, 16 bits
//
// one item is accepted per cycle while the pipeline advances; most of its depth is
// the 31-bit arcsine search, which runs a 26-stage sine unit for each bit.
// all stages advance together whenever the output register is empty or taken.
// synchronous reset clears the valid bits and loads the radius with 6371.

module great_circle_distance import gcd_pkg::*; #(
    parameter int ANGLE_WIDTH    = ANGLE_WIDTH_DEF,
    parameter int DIST_FRAC_BITS = DIST_FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    gcd_in_if.sink              i_pt,
    gcd_out_if.source           o_dist,
    input  logic                i_cfg_we,
    input  logic [RADIUS_W-1:0] i_cfg_data
);

    localparam int AW  = ANGLE_WIDTH;
    localparam int AW1 = AW + 1;
    localparam int UP  = (AW < 33) ? 33 - AW : 0;
    localparam int DN  = (AW > 33) ? AW - 33 : 0;
    localparam int MW  = AW1 + UP;
    localparam int SH  = QF - DIST_FRAC_BITS;

    localparam int V_HU    = 4 + SINE_LAT + 2;
    localparam int V_V     = V_HU + 1;
    localparam int SEL_DLY = ISQ_BITS + ASIN_LAT;
    localparam int V_ANG   = V_V + SEL_DLY + 1;
    localparam int LAT     = V_ANG + 3;

    // magnitude scaled to q30
    function automatic logic [Q_W-1:0] to_q30(input logic [AW:0] m);
        logic [MW-1:0] w;
        w = MW'(m) << UP;
        return Q_W'(w >> DN);
    endfunction

    // magnitude of a signed difference
    function automatic logic [AW:0] abs_diff(input logic signed [AW-1:0] a,
                                             input logic signed [AW-1:0] b);
        logic signed [AW:0] ea;
        logic signed [AW:0] eb;
        logic signed [AW:0] d;
        ea = a;
        eb = b;
        d  = ea - eb;
        return d[AW] ? AW1'(-d) : AW1'(d);
    endfunction

    // number of whole half turns to remove
    function automatic logic [2:0] turns(input logic [Q_W-1:0] x);
        logic [2:0] n;
        n = '0;
        for (int k = 1; k < 7; k++) begin
            n = n + ((36'(x) > PI_MULT[k]) ? 3'd1 : 3'd0);
        end
        return n;
    endfunction

    logic                w_en;
    logic [LAT-1:0]      r_vld;
    logic [RADIUS_W-1:0] r_radius;

    logic [Q_W-1:0] r_p1_x [4];
    logic [Q_W-1:0] r_p2_x [4];
    logic [2:0]     r_p2_n [4];
    logic [31:0]    r_p3_x [4];
    logic           r_p3_ng [4];
    logic [30:0]    r_p4_x [4];
    logic           r_p4_ng;
    logic [30:0]    w_s [4];

    logic [SINE_LAT-1:0] r_ngd;
    logic [61:0]         w_sa, w_sb, w_sc;
    logic [31:0]         r_a, r_b, r_cc, r_a6;
    logic                r_ng5, r_ng6;
    logic [63:0]         w_pp;
    logic [33:0]         r_p;
    logic signed [35:0]  w_h;
    logic [30:0]         r_hu;
    logic [29:0]         r_v;
    logic                r_sel;
    logic [SEL_DLY-1:0]  r_seld;
    logic [61:0]         w_rem [ISQ_BITS+1];
    logic [29:0]         w_root [ISQ_BITS+1];
    logic [30:0]         w_th;
    logic [30:0]         r_ang;
    logic [47:0]         r_d;
    logic [48:0]         w_rnd;
    logic [48:0]         w_shd;
    logic [DIST_W-1:0]   r_dist;

    // whole pipeline moves when the output register can take a new item
    assign w_en       = !r_vld[LAT-1] || o_dist.ready;
    assign i_pt.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_pt.valid};
        end
    end

    // radius register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_data;
        end
    end

    // stage 1: half differences and cosine arguments in q30
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_x[0] <= to_q30(abs_diff(i_pt.lat_a, i_pt.lat_b)) >> 1;
            r_p1_x[1] <= to_q30(abs_diff(i_pt.lon_a, i_pt.lon_b)) >> 1;
            r_p1_x[2] <= to_q30(abs_diff(i_pt.lat_a, AW'(0))) + Q_W'(HALF_PI_Q);
            r_p1_x[3] <= to_q30(abs_diff(i_pt.lat_b, AW'(0))) + Q_W'(HALF_PI_Q);
        end
    end

    // stages 2 to 4: range reduction into [0, pi/2]
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r_p2_x[i]  <= r_p1_x[i];
                r_p2_n[i]  <= turns(r_p1_x[i]);
                r_p3_x[i]  <= 32'(36'(r_p2_x[i]) - PI_MULT[r_p2_n[i]]);
                r_p3_ng[i] <= r_p2_n[i][0];
                r_p4_x[i]  <= (r_p3_x[i] > 32'(HALF_PI_Q))
                              ? 31'(PI_Q - r_p3_x[i]) : r_p3_x[i][30:0];
            end
            r_p4_ng <= r_p3_ng[2] ^ r_p3_ng[3];
        end
    end

    // four sine units in parallel
    for (genvar i = 0; i < 4; i++) begin : g_sine
        gcd_sine u_sine (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x   (r_p4_x[i]),
            .o_s   (w_s[i])
        );
    end

    // cosine sign travels beside the sine units
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ngd <= {r_ngd[SINE_LAT-2:0], r_p4_ng};
        end
    end

    // stage 5: squares and cosine product
    assign w_sa = 62'(w_s[0]) * 62'(w_s[0]);
    assign w_sb = 62'(w_s[1]) * 62'(w_s[1]);
    assign w_sc = 62'(w_s[2]) * 62'(w_s[3]);
    // stage 6: cosine product times the longitude term
    assign w_pp = 64'(r_cc) * 64'(r_b);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a   <= w_sa[61:30];
            r_b   <= w_sb[61:30];
            r_cc  <= w_sc[61:30];
            r_ng5 <= r_ngd[SINE_LAT-1];
            r_p   <= w_pp[63:30];
            r_a6  <= r_a;
            r_ng6 <= r_ng5;
        end
    end

    // stage 7: sum and clamp to [0, 1]
    assign w_h = r_ng6 ? (36'(r_a6) - 36'(r_p)) : (36'(r_a6) + 36'(r_p));

    // stage 8: fold the upper half onto 1 - h
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_h < 0) begin
                r_hu <= '0;
            end else if (w_h > 36'(ONE_Q)) begin
                r_hu <= ONE_Q;
            end else begin
                r_hu <= w_h[30:0];
            end
            r_sel <= (r_hu > HALF_ONE);
            r_v   <= (r_hu > HALF_ONE) ? 30'(ONE_Q - r_hu) : r_hu[29:0];
        end
    end

    // square root, one result bit per stage
    assign w_rem[0]  = {2'b00, r_v, 30'd0};
    assign w_root[0] = '0;

    for (genvar j = 0; j < ISQ_BITS; j++) begin : g_isq
        localparam int B = ISQ_BITS - 1 - j;

        logic [61:0] w_inc;
        logic [61:0] r_rem;
        logic [29:0] r_root;

        assign w_inc = (62'(w_root[j]) << (B + 1)) + (62'd1 << (2 * B));

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (w_inc <= w_rem[j]) begin
                    r_rem  <= w_rem[j] - w_inc;
                    r_root <= w_root[j] | (30'd1 << B);
                end else begin
                    r_rem  <= w_rem[j];
                    r_root <= w_root[j];
                end
            end
        end

        assign w_rem[j+1]  = r_rem;
        assign w_root[j+1] = r_root;
    end

    // arcsine of the root
    gcd_asin u_asin (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_r   (w_root[ISQ_BITS]),
        .o_th  (w_th)
    );

    // fold choice travels beside the root and arcsine
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_seld <= {r_seld[SEL_DLY-2:0], r_sel};
        end
    end

    // final stages: unfold, scale by radius, round and saturate
    assign w_rnd = 49'(r_d) + (49'd1 << (SH - 1));
    assign w_shd = w_rnd >> SH;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ang <= r_seld[SEL_DLY-1] ? (HALF_PI_Q - w_th) : w_th;
            r_d   <= 48'({r_ang, 1'b0}) * 48'(r_radius);
            if (|w_shd[48:DIST_W]) begin
                r_dist <= '1;
            end else begin
                r_dist <= w_shd[DIST_W-1:0];
            end
        end
    end

    assign o_dist.valid    = r_vld[LAT-1];
    assign o_dist.distance = r_dist;

    // clamped haversine term never exceeds one
    a_hu_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[V_HU] |-> (r_hu <= ONE_Q))
        else $error("clamped h above one");

    // folded root argument stays within the lower half
    a_v_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[V_V] |-> (31'(r_v) <= HALF_ONE))
        else $error("root argument above one half");

    // central half angle never exceeds pi/2
    a_ang_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[V_ANG] |-> (r_ang <= HALF_PI_Q))
        else $error("angle above pi/2");

endmodule

FILE: tb/sv/gcd_checker.sv
`timescale 1ns / 1ps
// gcd_checker: watches the point and distance channels, predicts each distance, compares
// depends on gcd_pkg, gcd_in_if and gcd_out_if

module gcd_checker import gcd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    gcd_in_if                   i_pt,
    gcd_out_if                  i_dist,
    input  logic                i_cfg_we,
    input  logic [RADIUS_W-1:0] i_cfg_data,
    output int                  o_pending,
    output int                  o_errors,
    output int                  o_checked
);

    typedef longint unsigned u64_t;

    localparam u64_t ONE      = u64_t'(1) << QF;
    localparam u64_t PI_V     = 64'd3373259426;
    localparam u64_t HALF_PI  = 64'd1686629713;
    localparam int   ANG_FRAC = ANGLE_WIDTH_DEF - 3;
    localparam int   ROUND_SH = QF - DIST_FRAC_BITS_DEF;
    localparam u64_t DIST_TOP = (u64_t'(1) << DIST_W) - 1;

    logic [RADIUS_W-1:0] radius_km;
    logic [DIST_W-1:0]   distance_q[$];
    int                  outstanding = 0;
    int                  errors      = 0;
    int                  checked     = 0;

    // taylor-style nested series on [0, pi/2]
    function automatic u64_t sine_series(input u64_t x);
        u64_t x2, t, dv;
        x2 = (x * x) >> QF;
        t  = ONE;
        for (int k = 8; k >= 1; k--) begin
            dv = u64_t'(2 * k) * u64_t'(2 * k + 1);
            t  = ONE - (x2 * t) / (dv << QF);
        end
        return (x * t) >> QF;
    endfunction

    // range reduction by whole multiples of pi, then fold about pi/2
    function automatic u64_t sine_folded(input u64_t x, output bit neg);
        neg = 1'b0;
        for (int i = 0; i < 6; i++) begin
            if (x > PI_V) begin
                x   = x - PI_V;
                neg = !neg;
            end
        end
        if (x > HALF_PI)
            x = PI_V - x;
        return sine_series(x);
    endfunction

    function automatic u64_t root_floor(input u64_t v);
        u64_t res, b;
        res = 0;
        b   = u64_t'(1) << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // bitwise search for the largest angle whose sine does not exceed r
    function automatic u64_t arc_sine(input u64_t r);
        u64_t th, c;
        th = 0;
        for (int b = QF; b >= 0; b--) begin
            c = th | (u64_t'(1) << b);
            if (c <= HALF_PI && sine_series(c) <= r)
                th = c;
        end
        return th;
    endfunction

    function automatic u64_t angle_q30(input longint a);
        u64_t m;
        m = (a < 0) ? u64_t'(-a) : u64_t'(a);
        return m << (QF - ANG_FRAC);
    endfunction

    function automatic u64_t half_diff_sine_sq(input longint d);
        u64_t s;
        bit   n;
        s = sine_folded(angle_q30(d) >> 1, n);
        return (s * s) >> QF;
    endfunction

    function automatic logic [DIST_W-1:0] haversine_distance(
        input logic signed [ANGLE_WIDTH_DEF-1:0] lat_a, lon_a, lat_b, lon_b,
        input logic [RADIUS_W-1:0] radius
    );
        longint la, oa, lb, ob, h;
        u64_t   sa, sb, ca, cb, p, th, d;
        bit     na, nb;
        la = lat_a;
        oa = lon_a;
        lb = lat_b;
        ob = lon_b;
        sa = half_diff_sine_sq(la - lb);
        sb = half_diff_sine_sq(oa - ob);
        ca = sine_folded(angle_q30(la) + HALF_PI, na);
        cb = sine_folded(angle_q30(lb) + HALF_PI, nb);
        p  = (((ca * cb) >> QF) * sb) >> QF;
        h  = (na != nb) ? longint'(sa) - longint'(p) : longint'(sa) + longint'(p);
        // rounding may push h just outside [0,1]
        if (h < 0)
            h = 0;
        if (h > longint'(ONE))
            h = longint'(ONE);
        if (u64_t'(h) <= (ONE >> 1))
            th = arc_sine(root_floor(u64_t'(h) << QF));
        else
            th = HALF_PI - arc_sine(root_floor((ONE - u64_t'(h)) << QF));
        d = (2 * th) * u64_t'(radius);
        d = (d + (u64_t'(1) << (ROUND_SH - 1))) >> ROUND_SH;
        if (d > DIST_TOP)
            d = DIST_TOP;
        return d[DIST_W-1:0];
    endfunction

    // radius tracking, prediction on each accepted item, comparison on each result
    always @(posedge i_clk) begin
        logic [DIST_W-1:0] want;
        if (!i_rst_n) begin
            radius_km <= RADIUS_RESET;
        end else begin
            if (i_cfg_we)
                radius_km <= i_cfg_data;
            if (i_pt.valid && i_pt.ready) begin
                distance_q = {distance_q,
                              haversine_distance(i_pt.lat_a, i_pt.lon_a,
                                                 i_pt.lat_b, i_pt.lon_b, radius_km)};
                outstanding++;
            end
            if (i_dist.valid && i_dist.ready) begin
                if (distance_q.size() == 0) begin
                    $display("%0t: distance %h with nothing outstanding", $time,
                             i_dist.distance);
                    errors++;
                end else begin
                    want = distance_q.pop_front();
                    outstanding--;
                    checked++;
                    if (want !== i_dist.distance) begin
                        $display("%0t: distance mismatch, expected %h, actual %h", $time,
                                 want, i_dist.distance);
                        errors++;
                    end
                end
            end
        end
    end

    assign o_pending = outstanding;
    assign o_errors  = errors;
    assign o_checked = checked;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: stimulus and verdict for great_circle_distance over several sphere radii
// depends on gcd_pkg, gcd_in_if, gcd_out_if, gcd_checker and the block itself

module tb;
    import gcd_pkg::*;

    localparam longint ANG_MAX     = 64'sd1686629713;
    localparam int     LATENCY     = 904;
    localparam int     PER_PHASE   = 140;
    localparam int     BIG_PHASE   = 1100;
    localparam int     HOLD_CYCLES = 2000;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    logic [RADIUS_W-1:0] cfg_data;
    int                  pending, errors, checked, sent;
    bit                  steady_send;
    bit                  hold_go;
    bit                  hold_done;

    gcd_in_if  pt_ch ();
    gcd_out_if dist_ch ();

    great_circle_distance dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pt       (pt_ch.sink),
        .o_dist     (dist_ch.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    gcd_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pt       (pt_ch),
        .i_dist     (dist_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .o_pending  (pending),
        .o_errors   (errors),
        .o_checked  (checked)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // overall time limit
    initial begin
        #4ms;
        $display("tb: done, errors");
        $finish;
    end

    // result side: random stalls, one long hold-off on request, and a calm stretch
    initial begin
        int cyc;
        dist_ch.ready = 1'b0;
        hold_done     = 1'b0;
        cyc = 0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (hold_go && !hold_done) begin
                dist_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                cyc += HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (cyc > 6000 && cyc < 7500)
                dist_ch.ready = 1'b1;
            else
                dist_ch.ready = ($urandom_range(99) >= 26);
        end
    end

    task automatic send_points(input longint la, oa, lb, ob);
        if (!steady_send && $urandom_range(99) < 26) begin
            pt_ch.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        pt_ch.valid = 1'b1;
        pt_ch.lat_a = la[31:0];
        pt_ch.lon_a = oa[31:0];
        pt_ch.lat_b = lb[31:0];
        pt_ch.lon_b = ob[31:0];
        do @(posedge i_clk); while (!pt_ch.ready);
        @(negedge i_clk);
        sent++;
    endtask

    // writes only with nothing in flight
    task automatic set_radius(input logic [RADIUS_W-1:0] r);
        pt_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_data = r;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    function automatic longint any_angle();
        case ($urandom_range(9))
            0, 1:    return longint'($signed($urandom()));
            default: return longint'($urandom_range(0, 32'd3373259426)) - ANG_MAX;
        endcase
    endfunction

    task automatic random_points();
        longint la, oa, d;
        la = any_angle();
        oa = any_angle();
        case ($urandom_range(9))
            // nearby points
            0, 1, 2: begin
                d = longint'($urandom_range(0, 2 ** 20)) - 2 ** 19;
                send_points(la, oa, la + d, oa - d);
            end
            // near-antipodal points
            3, 4: begin
                d = longint'($urandom_range(0, 4096)) - 2048;
                send_points(la, oa, -la + d, (oa > 0) ? oa - ANG_MAX + d : oa + ANG_MAX - d);
            end
            default: send_points(la, oa, any_angle(), any_angle());
        endcase
    endtask

    initial begin
        logic [RADIUS_W-1:0] radii[6];
        i_rst_n     = 1'b0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        pt_ch.valid = 1'b0;
        pt_ch.lat_a = '0;
        pt_ch.lon_a = '0;
        pt_ch.lat_b = '0;
        pt_ch.lon_b = '0;
        sent        = 0;
        steady_send = 1'b0;
        hold_go     = 1'b0;
        radii       = '{16'd6371, 16'd1, 16'd65535, 16'd0, 16'($urandom_range(2, 65534)),
                        16'd6371};
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed items at the reset radius
        send_points(0, 0, 0, 0);
        send_points(12345, -6789, 12345, -6789);
        send_points(ANG_MAX, ANG_MAX, ANG_MAX, ANG_MAX);
        send_points(-ANG_MAX, -ANG_MAX, ANG_MAX, ANG_MAX);
        send_points(ANG_MAX, 0, -ANG_MAX, 0);
        send_points(0, -ANG_MAX, 0, ANG_MAX);
        send_points(0, 0, 0, ANG_MAX);                       // antipodes on the equator
        send_points(0, ANG_MAX / 2, 0, -ANG_MAX / 2);
        send_points(0, 0, 0, ANG_MAX / 2);                   // h right at one half
        send_points(ANG_MAX / 2, 0, -ANG_MAX / 2, 0);
        send_points(ANG_MAX / 2, 0, 0, 0);
        send_points(-2 ** 31, -2 ** 31, 2 ** 31 - 1, 2 ** 31 - 1);
        send_points(2 ** 31 - 1, -2 ** 31, -2 ** 31, 2 ** 31 - 1);
        send_points(-2 ** 31, 0, -2 ** 31, 0);
        send_points(1, 0, 0, 1);
        send_points(-1, -1, 1, 1);
        send_points(ANG_MAX, 123456789, ANG_MAX - 1, -987654321);
        send_points(ANG_MAX - 3, 0, -ANG_MAX + 3, 1);
        send_points(0, 2 ** 31 - 1, 0, 0);
        send_points(700000000, -1500000000, -300000000, 1400000000);

        // random items over several radii, extremes among them; the long
        // phase holds the result side off so the pipeline fills and stalls
        foreach (radii[p]) begin
            set_radius(radii[p]);
            for (int n = 0; n < ((p == 2) ? BIG_PHASE : PER_PHASE); n++) begin
                steady_send = (p == 2 && n >= 50 && n < 200);
                if (p == 2 && n == 50)
                    hold_go = 1'b1;
                random_points();
            end
            steady_send = 1'b0;
            if (p == 3)
                send_points(ANG_MAX, ANG_MAX, -ANG_MAX, -ANG_MAX);
        end
        pt_ch.valid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 100) @(negedge i_clk);

        $display("tb: %0d point pairs sent, %0d distances checked", sent, checked);
        $display("tb: radii 6371, 1, 65535, 0 and %0d, with stalls and a long hold-off",
                 radii[4]);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

FILE: files.f
rtl/gcd_pkg.sv
rtl/gcd_in_if.sv
rtl/gcd_out_if.sv
rtl/gcd_sine.sv
rtl/gcd_asin.sv
rtl/great_circle_distance.sv
tb/sv/gcd_checker.sv
tb/sv/tb.sv
